// ===== sv/gscl_pkg.sv =====
`default_nettype none

package gscl_pkg;

    // Geometry
    localparam int SLOT_COUNT_DEF = 32;
    localparam int CODE_W         = 16;
    localparam int SLOT_W         = 5;

    // Action codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_UNLOCK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [CODE_W-1:0] char_code;
        logic              last_in_string;
    } in_beat_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot_index;
        logic              installed;
        logic              evicted_valid;
        logic [CODE_W-1:0] evicted_code;
        logic              no_free_slot;
        logic              skipped;
        logic              string_changed;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== sv/gscl_ram.sv =====
`default_nettype none

module gscl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/glyph_slot_cache_with_locks.sv =====
// A lookup beat scans every slot through the RAM read port, then loads its result into
// the output register once it is free; an unlock or zero-code beat skips the scan.
// One beat is in flight at a time: the input stalls until the result is loaded, and the
// single compare unit visits one slot per cycle through the RAM read port.
// Reset: asynchronous, active low; all slots read as empty, all locks and the
// string change flag clear at once, no clearing pass.
`default_nettype none

module glyph_slot_cache_with_locks #(
    parameter int SLOT_COUNT = gscl_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire gscl_pkg::in_beat_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output gscl_pkg::out_beat_t      out_data
);

    import gscl_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic                  last_reg, last_next;
    logic                  skip_reg, skip_next;
    logic                  unlock_reg, unlock_next;

    logic [IDX_W-1:0]      iss_cnt_reg, iss_cnt_next;
    logic                  iss_on_reg, iss_on_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                  chk_on_reg, chk_on_next;

    logic                  hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic                  emp_found_reg, emp_found_next;
    logic [IDX_W-1:0]      emp_idx_reg, emp_idx_next;
    logic                  unl_found_reg, unl_found_next;
    logic [IDX_W-1:0]      unl_idx_reg, unl_idx_next;
    logic [CODE_W-1:0]     unl_code_reg, unl_code_next;

    logic [SLOT_COUNT-1:0] slot_vld_reg, slot_vld_next;
    logic [SLOT_COUNT-1:0] slot_lock_reg, slot_lock_next;
    logic                  change_seen_reg, change_seen_next;

    logic                  out_valid_reg, out_valid_next;
    out_beat_t             out_data_reg, out_data_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [CODE_W-1:0]     ram_rdata;
    logic [CODE_W-1:0]     rd_code;
    logic                  rd_locked;
    logic [IDX_W-1:0]      fin_idx;
    logic [IDX_W+SLOT_W-1:0] fin_idx_ext;
    logic                  fin_inst;
    logic                  fin_changed;
    logic                  out_free;

    // Slot code store
    gscl_ram #(
        .WIDTH (CODE_W),
        .DEPTH (SLOT_COUNT)
    ) u_code_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (code_reg),
        .raddr (iss_cnt_reg),
        .rdata (ram_rdata)
    );

    // Entry that was never written reads as empty
    assign rd_code   = slot_vld_reg[chk_idx_reg] ? ram_rdata : '0;
    assign rd_locked = slot_lock_reg[chk_idx_reg];

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Result slot choice: the hit slot, else a victim slot
    always_comb
    begin
        fin_inst = 1'b0;
        fin_idx  = '0;
        priority if (skip_reg)
        begin
            fin_idx = '0;
        end
        else if (hit_found_reg)
        begin
            fin_idx = hit_idx_reg;
        end
        else if (emp_found_reg)
        begin
            fin_idx  = emp_idx_reg;
            fin_inst = 1'b1;
        end
        else if (unl_found_reg)
        begin
            fin_idx  = unl_idx_reg;
            fin_inst = 1'b1;
        end
        else
        begin
            fin_idx = '0;
        end
    end

    assign fin_idx_ext = {{SLOT_W{1'b0}}, fin_idx};
    assign fin_changed = change_seen_reg || fin_inst;
    assign ram_we      = (state_reg == ST_FIN) && out_free && fin_inst;
    assign ram_waddr   = fin_idx;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        code_next        = code_reg;
        last_next        = last_reg;
        skip_next        = skip_reg;
        unlock_next      = unlock_reg;
        iss_cnt_next     = iss_cnt_reg;
        iss_on_next      = iss_on_reg;
        chk_idx_next     = chk_idx_reg;
        chk_on_next      = chk_on_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        emp_found_next   = emp_found_reg;
        emp_idx_next     = emp_idx_reg;
        unl_found_next   = unl_found_reg;
        unl_idx_next     = unl_idx_reg;
        unl_code_next    = unl_code_reg;
        slot_vld_next    = slot_vld_reg;
        slot_lock_next   = slot_lock_reg;
        change_seen_next = change_seen_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    code_next      = in_data.char_code;
                    last_next      = in_data.last_in_string;
                    unlock_next    = (in_data.action == ACT_UNLOCK);
                    skip_next      = (in_data.action == ACT_UNLOCK)
                                     || (in_data.char_code == '0);
                    iss_cnt_next   = '0;
                    iss_on_next    = 1'b1;
                    chk_on_next    = 1'b0;
                    hit_found_next = 1'b0;
                    emp_found_next = 1'b0;
                    unl_found_next = 1'b0;
                    if ((in_data.action == ACT_UNLOCK) || (in_data.char_code == '0))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Advance the read address
                chk_on_next  = iss_on_reg;
                chk_idx_next = iss_cnt_reg;
                if (iss_on_reg)
                begin
                    if (iss_cnt_reg == LAST_IDX)
                    begin
                        iss_on_next = 1'b0;
                    end
                    else
                    begin
                        iss_cnt_next = iss_cnt_reg + 1'b1;
                    end
                end

                // Compare one slot per cycle
                if (chk_on_reg)
                begin
                    if ((rd_code == code_reg) && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                    end
                    if (!rd_locked && (rd_code == '0) && !emp_found_reg)
                    begin
                        emp_found_next = 1'b1;
                        emp_idx_next   = chk_idx_reg;
                    end
                    if (!rd_locked && !unl_found_reg)
                    begin
                        unl_found_next = 1'b1;
                        unl_idx_next   = chk_idx_reg;
                        unl_code_next  = rd_code;
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                // Commit state and load the result beat
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.hit            = !skip_reg && hit_found_reg;
                    out_data_next.slot_index     = fin_idx_ext[SLOT_W-1:0];
                    out_data_next.installed      = fin_inst;
                    out_data_next.evicted_valid  = fin_inst && !emp_found_reg;
                    out_data_next.evicted_code   = (fin_inst && !emp_found_reg)
                                                   ? unl_code_reg : '0;
                    out_data_next.no_free_slot   = !skip_reg && !hit_found_reg
                                                   && !unl_found_reg;
                    out_data_next.skipped        = skip_reg;
                    out_data_next.string_changed = last_reg && fin_changed;

                    if (unlock_reg)
                    begin
                        slot_lock_next = '0;
                    end
                    if (fin_inst)
                    begin
                        slot_vld_next[fin_idx]  = 1'b1;
                        slot_lock_next[fin_idx] = 1'b1;
                    end
                    change_seen_next = last_reg ? 1'b0 : fin_changed;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            iss_on_reg      <= 1'b0;
            chk_on_reg      <= 1'b0;
            slot_vld_reg    <= '0;
            slot_lock_reg   <= '0;
            change_seen_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            iss_on_reg      <= iss_on_next;
            chk_on_reg      <= chk_on_next;
            slot_vld_reg    <= slot_vld_next;
            slot_lock_reg   <= slot_lock_next;
            change_seen_reg <= change_seen_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        last_reg      <= last_next;
        skip_reg      <= skip_next;
        unlock_reg    <= unlock_next;
        iss_cnt_reg   <= iss_cnt_next;
        chk_idx_reg   <= chk_idx_next;
        hit_found_reg <= hit_found_next;
        hit_idx_reg   <= hit_idx_next;
        emp_found_reg <= emp_found_next;
        emp_idx_reg   <= emp_idx_next;
        unl_found_reg <= unl_found_next;
        unl_idx_reg   <= unl_idx_next;
        unl_code_reg  <= unl_code_next;
        out_data_reg  <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== sim/glyph_slot_cache_with_locks_test.sv =====
`timescale 1ns / 1ps

module glyph_slot_cache_with_locks_test;

    import gscl_pkg::*;

    localparam int SLOTS          = SLOT_COUNT_DEF;
    localparam int RANDOM_BEATS   = 1630;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int STUCK_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = SLOTS + 8;

    typedef struct {
        in_beat_t  beat;
        bit        typed;
        out_beat_t want;
    } plan_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;

    // Shadow copy of the slot store
    logic [CODE_W-1:0] held_code [SLOTS];
    bit                held_lock [SLOTS];
    bit                string_dirty;

    out_beat_t pending_results [$];
    plan_row_t plan_rows [$];
    int        mismatches;
    int        result_count;
    int        quiet_cycles;
    int        burst_left;
    bit        hold_req;

    glyph_slot_cache_with_locks dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Look up one beat in the shadow store and update it
    function automatic out_beat_t glyph_lookup(input in_beat_t b);
        out_beat_t r;
        int        i;
        int        found;
        int        victim;
        r     = '0;
        found = -1;
        victim = -1;
        if (b.action == ACT_UNLOCK)
        begin
            for (i = 0; i < SLOTS; i++)
                held_lock[i] = 1'b0;
            r.skipped = 1'b1;
        end
        else if (b.char_code == '0)
        begin
            r.skipped = 1'b1;
        end
        else
        begin
            for (i = 0; i < SLOTS; i++)
                if (found < 0 && held_code[i] == b.char_code)
                    found = i;
            if (found >= 0)
            begin
                r.hit        = 1'b1;
                r.slot_index = SLOT_W'(found);
            end
            else
            begin
                // Prefer an empty unlocked slot, else the first unlocked one
                for (i = 0; i < SLOTS; i++)
                    if (victim < 0 && !held_lock[i] && held_code[i] == '0)
                        victim = i;
                for (i = 0; i < SLOTS; i++)
                    if (victim < 0 && !held_lock[i])
                        victim = i;
                if (victim < 0)
                begin
                    r.no_free_slot = 1'b1;
                end
                else
                begin
                    if (held_code[victim] != '0)
                    begin
                        r.evicted_valid = 1'b1;
                        r.evicted_code  = held_code[victim];
                    end
                    held_code[victim] = b.char_code;
                    held_lock[victim] = 1'b1;
                    r.slot_index      = SLOT_W'(victim);
                    r.installed       = 1'b1;
                    string_dirty      = 1'b1;
                end
            end
        end
        if (b.last_in_string)
        begin
            r.string_changed = string_dirty;
            string_dirty     = 1'b0;
        end
        return r;
    endfunction

    function automatic in_beat_t beat_of(input logic act, input logic [CODE_W-1:0] code,
                                         input logic last);
        in_beat_t b;
        b.action         = act;
        b.char_code      = code;
        b.last_in_string = last;
        return b;
    endfunction

    function automatic out_beat_t skip_res(input logic changed);
        out_beat_t r;
        r                = '0;
        r.skipped        = 1'b1;
        r.string_changed = changed;
        return r;
    endfunction

    function automatic out_beat_t fill_res(input int slot, input logic changed);
        out_beat_t r;
        r                = '0;
        r.installed      = 1'b1;
        r.slot_index     = SLOT_W'(slot);
        r.string_changed = changed;
        return r;
    endfunction

    function automatic out_beat_t hit_res(input int slot, input logic changed);
        out_beat_t r;
        r                = '0;
        r.hit            = 1'b1;
        r.slot_index     = SLOT_W'(slot);
        r.string_changed = changed;
        return r;
    endfunction

    task automatic add_row(input in_beat_t b, input bit typed, input out_beat_t want);
        plan_row_t row;
        row.beat  = b;
        row.typed = typed;
        row.want  = want;
        plan_rows.insert(plan_rows.size(), row);
    endtask

    // Queue one expected result at the tail
    task automatic expect_result(input out_beat_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        mismatches++;
        if (mismatches <= 10)
            $display("result %0d, %s: got %0h, expected %0h", result_count, what, got, want);
    endtask

    task automatic check_fields(input out_beat_t got, input out_beat_t want);
        if (got.hit !== want.hit)
            log_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.slot_index !== want.slot_index)
            log_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
        if (got.installed !== want.installed)
            log_mismatch("installed", 32'(got.installed), 32'(want.installed));
        if (got.evicted_valid !== want.evicted_valid)
            log_mismatch("evicted_valid", 32'(got.evicted_valid), 32'(want.evicted_valid));
        if (got.evicted_code !== want.evicted_code)
            log_mismatch("evicted_code", 32'(got.evicted_code), 32'(want.evicted_code));
        if (got.no_free_slot !== want.no_free_slot)
            log_mismatch("no_free_slot", 32'(got.no_free_slot), 32'(want.no_free_slot));
        if (got.skipped !== want.skipped)
            log_mismatch("skipped", 32'(got.skipped), 32'(want.skipped));
        if (got.string_changed !== want.string_changed)
            log_mismatch("string_changed", 32'(got.string_changed),
                         32'(want.string_changed));
    endtask

    // Offer one beat from a falling edge, hold it until taken, return at a falling edge
    task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
        out_beat_t model_res;
        in_data  <= b;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        model_res = glyph_lookup(b);
        expect_result(typed ? want : model_res);
        @(negedge clk);
    endtask

    // Idle the input for a random gap, mostly short
    task automatic rest_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if (pick < 2)
        begin
            burst_left = $urandom_range(50, 150);
            gap = 0;
        end
        else if (pick < 60)
            gap = 0;
        else if (pick < 88)
            gap = $urandom_range(1, 3);
        else if (pick < 97)
            gap = $urandom_range(4, 20);
        else
            gap = $urandom_range(30, 80);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid and hold until every expected result is back
    task automatic drain_pause();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sample the result side and track progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected: %p",
                                 result_count, out_data);
                end
                else
                    check_fields(out_data, pending_results.pop_front());
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Drive the result-side stall, with one long hold-off on request
    initial
    begin : result_sink
        bit stall_now;
        int run;
        int pick;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req  = 1'b0;
                stall_now = 1'b1;
                run       = RX_HOLD_CYCLES;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    stall_now = 1'b0;
                    run       = $urandom_range(1, 4);
                end
                else if (pick < 80)
                begin
                    stall_now = 1'b1;
                    run       = $urandom_range(1, 3);
                end
                else if (pick < 94)
                begin
                    stall_now = 1'b0;
                    run       = $urandom_range(5, 30);
                end
                else if (pick < 98)
                begin
                    stall_now = 1'b1;
                    run       = $urandom_range(10, 60);
                end
                else
                begin
                    stall_now = 1'b0;
                    run       = $urandom_range(100, 300);
                end
            end
            out_stall <= stall_now;
            repeat (run) @(negedge clk);
        end
    end

    // End the run if nothing moves for too long
    initial
    begin : watchdog
        @(posedge rst_n);
        while (quiet_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int                r;
        int                k;
        int                pick;
        int                span;
        int                base;
        int                strings;
        int                len;
        int                cache_beats;
        bit                hold_used;
        bit                pause_used;
        logic              act;
        logic              last;
        logic [CODE_W-1:0] code;

        for (r = 0; r < SLOTS; r++)
        begin
            held_code[r] = '0;
            held_lock[r] = 1'b0;
        end
        string_dirty = 1'b0;
        cache_beats  = 0;
        hold_used    = 1'b0;
        pause_used   = 1'b0;
        base         = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats: empty code, unlock, extremes, hits, string flag
        add_row(beat_of(ACT_LOOKUP, 16'h0000, 1'b0), 1'b1, skip_res(1'b0));
        add_row(beat_of(ACT_UNLOCK, 16'hFFFF, 1'b1), 1'b1, skip_res(1'b0));
        add_row(beat_of(ACT_LOOKUP, 16'hFFFF, 1'b0), 1'b1, fill_res(0, 1'b0));
        add_row(beat_of(ACT_LOOKUP, 16'hFFFF, 1'b1), 1'b1, hit_res(0, 1'b1));
        add_row(beat_of(ACT_LOOKUP, 16'h0001, 1'b0), 1'b1, fill_res(1, 1'b0));
        add_row(beat_of(ACT_LOOKUP, 16'h8000, 1'b0), 1'b1, fill_res(2, 1'b0));
        add_row(beat_of(ACT_LOOKUP, 16'h0000, 1'b1), 1'b1, skip_res(1'b1));
        add_row(beat_of(ACT_LOOKUP, 16'h0000, 1'b1), 1'b1, skip_res(1'b0));
        add_row(beat_of(ACT_UNLOCK, 16'h0000, 1'b0), 1'b1, skip_res(1'b0));
        add_row(beat_of(ACT_LOOKUP, 16'h0001, 1'b1), 1'b1, hit_res(1, 1'b0));
        add_row(beat_of(ACT_LOOKUP, 16'h5555, 1'b0), 1'b1, fill_res(3, 1'b0));
        add_row(beat_of(ACT_LOOKUP, 16'hAAAA, 1'b1), 1'b1, fill_res(4, 1'b1));
        add_row(beat_of(ACT_UNLOCK, 16'hAAAA, 1'b1), 1'b1, skip_res(1'b0));
        add_row(beat_of(ACT_LOOKUP, 16'h7FFF, 1'b0), 1'b0, '0);
        add_row(beat_of(ACT_LOOKUP, 16'h0002, 1'b0), 1'b0, '0);
        add_row(beat_of(ACT_LOOKUP, 16'h5555, 1'b1), 1'b0, '0);
        add_row(beat_of(ACT_LOOKUP, 16'hFFFE, 1'b0), 1'b0, '0);
        add_row(beat_of(ACT_UNLOCK, 16'h0001, 1'b0), 1'b0, '0);
        add_row(beat_of(ACT_LOOKUP, 16'h8000, 1'b0), 1'b0, '0);
        add_row(beat_of(ACT_LOOKUP, 16'h1234, 1'b1), 1'b0, '0);
        add_row(beat_of(ACT_LOOKUP, 16'h0000, 1'b0), 1'b0, '0);
        add_row(beat_of(ACT_LOOKUP, 16'h4321, 1'b1), 1'b0, '0);

        @(negedge clk);
        foreach (plan_rows[i])
        begin
            send_beat(plan_rows[i].beat, plan_rows[i].typed, plan_rows[i].want);
            rest_gap();
        end
        drain_pause();

        // Random frames: optional unlock, then strings of codes from a moving window
        while (cache_beats < RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                span = $urandom_range(4, 36);
            else if (pick < 85)
                span = $urandom_range(37, 100);
            else
                span = 65535;
            if ($urandom_range(0, 7) == 0)
                base = $urandom_range(0, 65535);
            if ($urandom_range(0, 3) != 0)
            begin
                send_beat(beat_of(ACT_UNLOCK, CODE_W'($urandom_range(0, 65535)),
                                  1'($urandom_range(0, 1))), 1'b0, '0);
                rest_gap();
                cache_beats++;
            end
            strings = $urandom_range(1, 6);
            repeat (strings)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                begin
                    code = CODE_W'(base + $urandom_range(1, span));
                    if (code == '0)
                        code = 16'h0001;
                    act  = ACT_LOOKUP;
                    last = (k == len - 1);
                    // Mix in empty codes, stray unlocks and broken string ends
                    pick = $urandom_range(0, 99);
                    if (pick < 4)
                        code = '0;
                    else if (pick < 6)
                        act = ACT_UNLOCK;
                    else if (pick < 9)
                        last = ~last;
                    send_beat(beat_of(act, code, last), 1'b0, '0);
                    rest_gap();
                    if (act == ACT_UNLOCK || code != '0)
                        cache_beats++;
                    if (!hold_used && cache_beats >= 500)
                    begin
                        hold_used = 1'b1;
                        hold_req  = 1'b1;
                    end
                    if (!pause_used && cache_beats >= 1000)
                    begin
                        pause_used = 1'b1;
                        drain_pause();
                    end
                end
            end
        end

        drain_pause();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
